### rtl/ntbs_pkg.sv
// Package for the nearest-time baseline subtractor: sizes, codes, and the
// command/status structs passed between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ntbs_pkg;

  // Table size and derived widths
  localparam int CAL_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(CAL_ENTRIES);
  localparam int CNT_W       = $clog2(CAL_ENTRIES + 1);

  // Field widths
  localparam int EIDX_W  = 10;
  localparam int TIME_W  = 32;
  localparam int LVL_W   = 12;
  localparam int GAIN_W  = 8;
  localparam int ENTRY_W = TIME_W + LVL_W;
  localparam int PROD_W  = LVL_W + GAIN_W;
  localparam int DCNT_W  = $clog2(PROD_W);

  // Packed word widths
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 56;

  // Command codes carried in in_tuser
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;

  // Register indexes
  localparam logic REG_CALIB_GAIN  = 1'b0;
  localparam logic REG_SAMPLE_GAIN = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd10;

  typedef struct packed {
    logic wr;         // write table entry from input word
    logic load;       // capture sample, start search
    logic step;       // one lower-bound halving step
    logic rd_lo;      // read lower neighbor
    logic rd_hi;      // read upper neighbor, capture lower
    logic pick;       // choose nearest entry
    logic mul;        // level * sample_gain, arm divider
    logic div_step;   // one quotient bit
    logic finish;     // load output register
  } ntbs_cmd_t;

  typedef struct packed {
    logic search_done;
    logic div_last;
    logic out_free;
  } ntbs_sts_t;

endpackage

### rtl/ntbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ntbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/ntbs_ctrl.sv
// Sequencer for the baseline subtractor: accepts words, steps the search,
// neighbor fetch, multiply, divide and output load. Uses ntbs_pkg.
`timescale 1ns / 1ps

module ntbs_ctrl
  import ntbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tuser,
  output logic       in_tready,
  input  ntbs_sts_t  sts,
  output ntbs_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEARCH   = 3'd1;
  localparam logic [2:0] S_FETCH_LO = 3'd2;
  localparam logic [2:0] S_FETCH_HI = 3'd3;
  localparam logic [2:0] S_PICK     = 3'd4;
  localparam logic [2:0] S_MUL      = 3'd5;
  localparam logic [2:0] S_DIV      = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_tuser == CMD_WRITE)) begin
          cmd.wr = 1'b1;
        end
        if (accept && (in_tuser == CMD_CORRECT)) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.search_done) begin
          state_nxt = S_FETCH_LO;
        end
      end
      S_FETCH_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_FETCH_HI;
      end
      S_FETCH_HI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/ntbs_dp.sv
// Datapath: calibration table RAM, lower-bound search registers, nearest pick,
// gain multiply, restoring divider, output register. Uses ntbs_pkg, ntbs_ram.
`timescale 1ns / 1ps

module ntbs_dp
  import ntbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ntbs_cmd_t           cmd,
  output ntbs_sts_t           sts,
  // config
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [GAIN_W-1:0]   cfg_wdata,
  // input fields
  input  logic [EIDX_W-1:0]   entry_index,
  input  logic [TIME_W-1:0]   entry_time,
  input  logic [LVL_W-1:0]    entry_level,
  input  logic [TIME_W-1:0]   sample_time,
  input  logic [LVL_W-1:0]    sample_level,
  // result
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TIME_W-1:0]   time_out,
  output logic [LVL_W-1:0]    corrected_level,
  output logic [EIDX_W-1:0]   matched_index,
  output logic                was_corrected
);

  localparam logic [ADDR_W-1:0] HALF_ADDR = ADDR_W'(CAL_ENTRIES / 2);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAL_ENTRIES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAL_ENTRIES);

  // config registers
  logic [GAIN_W-1:0] calib_gain_r;
  logic [GAIN_W-1:0] sample_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_gain_r  <= GAIN_RESET;
      sample_gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_CALIB_GAIN) begin
        calib_gain_r <= cfg_wdata;
      end
      if (cfg_index == REG_SAMPLE_GAIN) begin
        sample_gain_r <= cfg_wdata;
      end
    end
  end

  // table memory: {time, level}
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [TIME_W-1:0]   rd_time;
  logic [LVL_W-1:0]    rd_level;

  // writes past the table are dropped
  assign ram_we = cmd.wr && (32'(entry_index) < CAL_ENTRIES);

  ntbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAL_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(entry_index)),
    .wdata ({entry_time, entry_level}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_time  = ram_rdata[ENTRY_W-1 -: TIME_W];
  assign rd_level = ram_rdata[LVL_W-1:0];

  // sample and search state
  logic [TIME_W-1:0] t_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [CNT_W-1:0]  first_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  probe;
  logic              below;
  logic [CNT_W-1:0]  first_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  next_probe;

  assign half       = count_r >> 1;
  assign probe      = first_r + half;
  assign below      = rd_time < t_r;
  assign first_nxt  = below ? probe + CNT_W'(1) : first_r;
  assign count_nxt  = below ? count_r - half - CNT_W'(1) : half;
  assign next_probe = first_nxt + (count_nxt >> 1);

  // neighbor indexes, clamped at the table ends
  logic              at_edge;
  logic [CNT_W-1:0]  first_m1;
  logic [ADDR_W-1:0] lo_idx;
  logic [ADDR_W-1:0] hi_idx;

  assign at_edge  = (first_r == '0) || (first_r >= FULL_CNT);
  assign first_m1 = first_r - CNT_W'(1);
  assign lo_idx   = (first_r == '0) ? '0 : first_m1[ADDR_W-1:0];
  assign hi_idx   = (first_r >= FULL_CNT) ? LAST_ADDR : first_r[ADDR_W-1:0];

  always_comb begin
    ram_raddr = HALF_ADDR;
    if (cmd.step) begin
      ram_raddr = next_probe[ADDR_W-1:0];
    end else if (cmd.rd_lo) begin
      ram_raddr = lo_idx;
    end else if (cmd.rd_hi) begin
      ram_raddr = hi_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r     <= sample_time;
      lvl_r   <= sample_level;
      first_r <= '0;
      count_r <= FULL_CNT;
    end else if (cmd.step) begin
      first_r <= first_nxt;
      count_r <= count_nxt;
    end
  end

  // nearest pick; tie goes to the later entry
  logic [TIME_W-1:0] lo_time_r;
  logic [LVL_W-1:0]  lo_level_r;
  logic              take_lo;
  logic [ADDR_W-1:0] k_r;
  logic [LVL_W-1:0]  base_r;

  assign take_lo = !at_edge && ((t_r - lo_time_r) < (rd_time - t_r));

  always_ff @(posedge clk) begin
    if (cmd.rd_hi) begin
      lo_time_r  <= rd_time;
      lo_level_r <= rd_level;
    end
    if (cmd.pick) begin
      k_r    <= take_lo ? lo_idx : hi_idx;
      base_r <= take_lo ? lo_level_r : rd_level;
    end
  end

  // multiply then restoring divide, one quotient bit per cycle
  logic [GAIN_W-1:0] div_r;
  logic [GAIN_W-1:0] rem_r;
  logic [PROD_W-1:0] quo_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [GAIN_W:0]   rem_sh;
  logic              ge;
  logic [GAIN_W:0]   rem_sub;

  assign rem_sh  = {rem_r, quo_r[PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r  <= PROD_W'(base_r) * PROD_W'(sample_gain_r);
      rem_r  <= '0;
      dcnt_r <= '0;
      div_r  <= (calib_gain_r == '0) ? GAIN_W'(1) : calib_gain_r;
    end else if (cmd.div_step) begin
      rem_r  <= ge ? rem_sub[GAIN_W-1:0] : rem_sh[GAIN_W-1:0];
      quo_r  <= {quo_r[PROD_W-2:0], ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // output register
  logic              out_valid_r;
  logic [TIME_W-1:0] time_out_r;
  logic [LVL_W-1:0]  corr_r;
  logic [EIDX_W-1:0] midx_r;
  logic              was_r;
  logic              exceeds;

  assign exceeds = PROD_W'(lvl_r) > quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      time_out_r <= t_r;
      corr_r     <= exceeds ? lvl_r - quo_r[LVL_W-1:0] : '0;
      midx_r     <= EIDX_W'(k_r);
      was_r      <= exceeds;
    end
  end

  assign out_valid       = out_valid_r;
  assign time_out        = time_out_r;
  assign corrected_level = corr_r;
  assign matched_index   = midx_r;
  assign was_corrected   = was_r;

  assign sts.search_done = (count_nxt == '0);
  assign sts.div_last    = (dcnt_r == DCNT_W'(PROD_W - 1));
  assign sts.out_free    = !out_valid_r || out_ready;

  // checks
  a_search_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (count_r != '0))
    else $error("search step with empty range");

  a_probe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (probe < FULL_CNT))
    else $error("search probe beyond table");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result overwrites pending output");

endmodule

### rtl/nearest_time_baseline_subtractor.sv
// Top level of the nearest-time baseline subtractor: unpacks the stream words
// and joins the controller to the datapath. Uses ntbs_pkg, ntbs_ctrl, ntbs_dp.
`timescale 1ns / 1ps
//
//  channel   dir   handshake          payload
//  in_       in    tvalid/tready      tuser: cmd; tdata: table entry or sample
//  out_      out   tvalid/tready      tdata: corrected sample
//  cfg_      in    cfg_we (no wait)   cfg_index selects calib_gain / sample_gain
//
//  A table write word is written to the table RAM on acceptance. A sample word holds the input
//  from its accept cycle on through one lower-bound step per cycle over the
//  single RAM read port (10 or 11 steps for 1024 entries), the neighbor reads,
//  pick and multiply, the one-bit-per-cycle restoring divider, and the load of
//  the output register.
//  The next word is taken while the last result waits in the output register;
//  a new result holds in the controller until out_tready frees that register.
//  Reset (rst_n, synchronous) clears control and the gain registers to 10;
//  the table is not cleared and must be written before it is searched.

module nearest_time_baseline_subtractor
  import ntbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input words
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic                   in_tuser,   // [0] cmd
  // [9:0] entry_index, [41:10] entry_time, [53:42] entry_level,
  // [85:54] sample_time, [97:86] sample_level, [103:98] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result words
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] time_out, [43:32] corrected_level, [53:44] matched_index,
  // [54] was_corrected, [55] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [GAIN_W-1:0]      cfg_wdata
);

  ntbs_cmd_t cmd;
  ntbs_sts_t sts;

  // input word fields
  logic [EIDX_W-1:0] entry_index;
  logic [TIME_W-1:0] entry_time;
  logic [LVL_W-1:0]  entry_level;
  logic [TIME_W-1:0] sample_time;
  logic [LVL_W-1:0]  sample_level;

  assign entry_index  = in_tdata[9:0];
  assign entry_time   = in_tdata[41:10];
  assign entry_level  = in_tdata[53:42];
  assign sample_time  = in_tdata[85:54];
  assign sample_level = in_tdata[97:86];

  // result fields
  logic [TIME_W-1:0] time_out;
  logic [LVL_W-1:0]  corrected_level;
  logic [EIDX_W-1:0] matched_index;
  logic              was_corrected;

  assign out_tdata = {1'b0, was_corrected, matched_index, corrected_level, time_out};

  ntbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ntbs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .entry_index     (entry_index),
    .entry_time      (entry_time),
    .entry_level     (entry_level),
    .sample_time     (sample_time),
    .sample_level    (sample_level),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .time_out        (time_out),
    .corrected_level (corrected_level),
    .matched_index   (matched_index),
    .was_corrected   (was_corrected)
  );

endmodule

### dv/nearest_time_baseline_subtractor_test.sv
// Self-checking bench for nearest_time_baseline_subtractor: loads a sorted table,
// fires samples under several gain settings and stall patterns, checks each result.
// Depends on ntbs_pkg and the nearest_time_baseline_subtractor RTL only.
`timescale 1ns / 1ps

module nearest_time_baseline_subtractor_test
  import ntbs_pkg::*;
();

  typedef struct packed {
    logic [TIME_W-1:0] time_out;
    logic [LVL_W-1:0]  level;
    logic [EIDX_W-1:0] slot;
    logic              reduced;
  } baseline_result_t;

  // Shadow of the table and gains; predicts one result per sample word.
  class baseline_board;
    logic [TIME_W-1:0] cal_t [CAL_ENTRIES];
    logic [LVL_W-1:0]  cal_l [CAL_ENTRIES];
    int unsigned       calib_g = 32'(GAIN_RESET);
    int unsigned       sample_g = 32'(GAIN_RESET);
    baseline_result_t  corrected_q[$];
    int                errors = 0;

    function void set_gain(logic idx, logic [GAIN_W-1:0] val);
      if (idx == REG_CALIB_GAIN) calib_g = 32'(val);
      else sample_g = 32'(val);
    endfunction

    // lower-bound search, then the nearer neighbor (tie goes to the later one)
    function int unsigned closest_slot(logic [TIME_W-1:0] t);
      int unsigned base = 0;
      int unsigned span = CAL_ENTRIES;
      int unsigned half;
      int unsigned probe;
      logic [TIME_W-1:0] gap_lo;
      logic [TIME_W-1:0] gap_hi;
      while (span > 0) begin
        half = span / 2;
        probe = base + half;
        if (cal_t[probe] < t) begin
          base = probe + 1;
          span -= half + 1;
        end else begin
          span = half;
        end
      end
      if (base == 0) return 0;
      if (base >= CAL_ENTRIES) return CAL_ENTRIES - 1;
      gap_lo = t - cal_t[base-1];
      gap_hi = cal_t[base] - t;
      return (gap_lo < gap_hi) ? base - 1 : base;
    endfunction

    function int unsigned scaled_baseline(int unsigned slot);
      int unsigned lv = 32'(cal_l[slot]);
      int unsigned dv = (calib_g == 0) ? 1 : calib_g;
      return (lv * sample_g) / dv;
    endfunction

    function void take_word(logic cmd, logic [IN_TDATA_W-1:0] w);
      baseline_result_t r;
      int unsigned slot;
      int unsigned corr;
      int unsigned lvl;
      if (cmd == CMD_WRITE) begin
        cal_t[w[9:0]] = w[41:10];
        cal_l[w[9:0]] = w[53:42];
      end else begin
        lvl = 32'(w[97:86]);
        slot = closest_slot(w[85:54]);
        corr = scaled_baseline(slot);
        r.time_out = w[85:54];
        r.slot = slot[EIDX_W-1:0];
        r.reduced = lvl > corr;
        r.level = r.reduced ? LVL_W'(lvl - corr) : '0;
        corrected_q.push_back(r);
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] w);
      baseline_result_t r;
      if (corrected_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing got %h", $time, w);
        errors++;
        return;
      end
      r = corrected_q.pop_front();
      compare_field("time_out", 64'(r.time_out), 64'(w[31:0]));
      compare_field("corrected_level", 64'(r.level), 64'(w[43:32]));
      compare_field("matched_index", 64'(r.slot), 64'(w[53:44]));
      compare_field("was_corrected", 64'(r.reduced), 64'(w[54]));
      compare_field("pad", 64'd0, 64'(w[55]));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic                   in_tuser = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic [GAIN_W-1:0]      cfg_wdata = '0;

  baseline_board board = new();

  int src_idle_pct = 0;   // chance per cycle that the sender holds back
  int sink_stall_pct = 0; // chance per cycle that the receiver drops tready
  int hold_left = 0;      // long receiver hold-off, counted down at negedge

  nearest_time_baseline_subtractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: tready moves at negedge, results are taken at posedge
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_word(out_tdata);
  end

  function automatic logic [IN_TDATA_W-1:0] pack_word(
      logic [EIDX_W-1:0] idx, logic [TIME_W-1:0] et, logic [LVL_W-1:0] el,
      logic [TIME_W-1:0] st, logic [LVL_W-1:0] sl);
    return {6'd0, sl, st, el, et, idx};
  endfunction

  // one word on the input channel; returns at the accepting posedge
  task automatic send_word(input logic cmd, input logic [IN_TDATA_W-1:0] w);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    board.take_word(cmd, w);
  endtask

  task automatic send_entry(input int unsigned idx, input logic [TIME_W-1:0] t,
                            input logic [LVL_W-1:0] lvl);
    send_word(CMD_WRITE, pack_word(EIDX_W'(idx), t, lvl, $urandom,
                                   LVL_W'($urandom_range(4095))));
  endtask

  task automatic send_sample(input logic [TIME_W-1:0] t, input logic [LVL_W-1:0] lvl);
    send_word(CMD_CORRECT, pack_word(EIDX_W'($urandom_range(1023)), $urandom,
                                     LVL_W'($urandom_range(4095)), t, lvl));
  endtask

  task automatic write_gain(input logic idx, input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_gain(idx, val);
  endtask

  // drop valid, wait for every result, then cover the sample pipeline latency
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.corrected_q.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic random_batch(input int n);
    int unsigned idx;
    int unsigned k;
    int unsigned corr;
    int v;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    logic [LVL_W-1:0] lvl;
    int pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        // mostly order-keeping rewrites; a few land anywhere and unsort the table
        idx = $urandom_range(CAL_ENTRIES - 1);
        lo = (idx == 0) ? '0 : board.cal_t[idx-1];
        hi = (idx == CAL_ENTRIES - 1) ? '1 : board.cal_t[idx+1];
        if ($urandom_range(99) < 85 && lo <= hi)
          t = lo + TIME_W'(longint'($urandom) % (longint'(hi) - longint'(lo) + 1));
        else
          t = $urandom;
        send_entry(idx, t, LVL_W'($urandom_range(4095)));
      end else begin
        k = $urandom_range(CAL_ENTRIES - 2);
        pick = $urandom_range(99);
        if (pick < 40)
          t = board.cal_t[k] + TIME_W'($urandom_range(6)) - 32'd3;
        else if (pick < 65)
          t = board.cal_t[k] + (board.cal_t[k+1] - board.cal_t[k]) / 2
              + TIME_W'($urandom_range(2)) - 32'd1;
        else if (pick < 85)
          t = $urandom;
        else if (pick < 95)
          t = board.cal_t[k];
        else
          t = $urandom_range(1) ? '1 : '0;
        // aim the level around the correction it will meet
        corr = board.scaled_baseline(board.closest_slot(t));
        pick = $urandom_range(99);
        if (pick < 50) begin
          lvl = LVL_W'($urandom_range(4095));
        end else if (pick < 80) begin
          v = int'(corr) + int'($urandom_range(4)) - 2;
          lvl = (v < 0) ? '0 : (v > 4095) ? '1 : LVL_W'(v);
        end else begin
          lvl = $urandom_range(1) ? '1 : '0;
        end
        send_sample(t, lvl);
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("nearest_time_baseline_subtractor_test NOT OK");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] mid;
    logic [TIME_W-1:0] keep_t;
    logic [LVL_W-1:0]  keep_l;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // whole table written first, so no search ever touches an unwritten entry
    t = $urandom_range(1000, 1);
    for (int i = 0; i < CAL_ENTRIES; i++) begin
      send_entry(i, t, LVL_W'($urandom_range(4095)));
      t += $urandom_range(4_000_000, 1);
    end

    // directed words, reset gains (10/10 so correction equals the baseline)
    send_sample('0, '1);                                   // below first entry
    send_sample('1, '0);                                   // past last entry
    send_sample(board.cal_t[0], '1);
    send_sample(board.cal_t[1023], board.cal_l[1023]);     // exactly equal: no reduction
    send_sample(board.cal_t[300],
                (board.cal_l[300] == '1) ? board.cal_l[300] : board.cal_l[300] + 1'b1);
    // exact midpoint between two entries must pick the later one
    if (((board.cal_t[501] - board.cal_t[500]) & 32'd1) != 0)
      send_entry(501, board.cal_t[501] - 1, board.cal_l[501]);
    mid = board.cal_t[500] + (board.cal_t[501] - board.cal_t[500]) / 2;
    send_sample(mid, LVL_W'($urandom_range(4095)));
    send_sample(mid - 1, LVL_W'($urandom_range(4095)));
    send_sample(mid + 1, LVL_W'($urandom_range(4095)));
    // field extremes on the table itself
    send_entry(1023, '1, '1);
    send_sample('1, '1);
    send_entry(0, '0, '0);
    send_sample('0, 12'd1);
    send_sample(32'd1, '0);
    // unsorted table: the search still halves the same way
    keep_t = board.cal_t[600];
    keep_l = board.cal_l[600];
    send_entry(600, '0, 12'd123);
    send_sample(keep_t, 12'd2000);
    send_sample($urandom, 12'd2000);
    send_entry(600, keep_t, keep_l);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          src_idle_pct = 0;  sink_stall_pct = 0;
          write_gain(REG_CALIB_GAIN, 8'd10);
          write_gain(REG_SAMPLE_GAIN, 8'd10);
        end
        1: begin
          src_idle_pct = 48; sink_stall_pct = 0;
          write_gain(REG_CALIB_GAIN, 8'd1);
          write_gain(REG_SAMPLE_GAIN, 8'd255);
        end
        2: begin
          src_idle_pct = 0;  sink_stall_pct = 48;
          write_gain(REG_CALIB_GAIN, 8'd255);
          write_gain(REG_SAMPLE_GAIN, 8'd1);
        end
        3: begin
          // zero calib gain divides by one
          src_idle_pct = 33; sink_stall_pct = 33;
          write_gain(REG_CALIB_GAIN, 8'd0);
          write_gain(REG_SAMPLE_GAIN, 8'd37);
        end
        4: begin
          // zero sample gain: nothing is subtracted; long hold-off fills the block
          src_idle_pct = 0;  sink_stall_pct = 0;
          write_gain(REG_CALIB_GAIN, 8'd7);
          write_gain(REG_SAMPLE_GAIN, 8'd0);
          @(posedge clk);
          hold_left = 400;
        end
        default: begin
          src_idle_pct = 33; sink_stall_pct = 33;
          write_gain(REG_CALIB_GAIN, GAIN_W'($urandom_range(255, 1)));
          write_gain(REG_SAMPLE_GAIN, GAIN_W'($urandom_range(255, 1)));
        end
      endcase
      random_batch(30);
      drain();
    end

    if (board.corrected_q.size() != 0)
      $display("%0t: results missing, expected %0d more got none", $time,
               board.corrected_q.size());
    if (board.errors == 0 && board.corrected_q.size() == 0) begin
      $display("nearest_time_baseline_subtractor_test OK");
    end else begin
      $display("nearest_time_baseline_subtractor_test NOT OK");
    end
    $finish;
  end

endmodule
